/* design/itf_pkg.sv */
`default_nettype none
package itf_pkg;

	localparam int VAL_W    = 64;
	localparam int BCD_DIGS = 20;
	localparam int BCD_W    = 4 * BCD_DIGS;
	localparam int PREC_W   = 6;
	localparam int IDX_W    = 5;

	localparam logic [PREC_W-1:0] MAX_PRECISION = 6'd61;

	// radix selector codes; anything else is hex
	localparam logic [1:0] ACT_DEC = 2'd0;
	localparam logic [1:0] ACT_OCT = 2'd1;

	// top digit index per radix
	localparam logic [IDX_W-1:0] TOP_DEC = 5'd19;
	localparam logic [IDX_W-1:0] TOP_OCT = 5'd21;
	localparam logic [IDX_W-1:0] TOP_HEX = 5'd15;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_NUL   = 8'h00;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UP_A : CH_LOW_A;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'b0, d};
		else
			digit_char = base + {4'b0, d} - 8'd10;
	endfunction

endpackage
`default_nettype wire

/* design/itf_bcd.sv */
`default_nettype none
module itf_bcd (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [itf_pkg::VAL_W-1:0]  value,
	output logic                            done,
	output logic [itf_pkg::BCD_W-1:0]       bcd
);
	import itf_pkg::*;

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0] shift_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= value;
			bcd_q   <= '0;
		end else if (busy_q) begin
			{bcd_q, shift_q} <= {adj[BCD_W-2:0], shift_q, 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

/* design/integer_to_text_formatter_top.sv */
`default_nettype none
// Integer to text formatter, printf style.
// Input channel (item_valid/item_ready): one beat carries a 64-bit magnitude,
// the radix selector in action (decimal, octal, else hex), sign and flag bits
// and a signed 7-bit precision. Output channel (res_valid/res_ready): one beat
// per character, most significant first, last set on the final one. An empty
// text goes out as a single beat with empty_res and last set.
// Flow per item: decimal first runs a shift-and-add-3 binary to BCD
// converter (64 shifts, one magnitude bit each), then all radixes scan down
// from the top digit for the leading nonzero one, one digit per cycle, then
// emit one character per cycle while the receiver takes them. item_ready is
// high only between items. When the receiver stalls, the character in the
// output register holds and the sequencer waits. The final beat of an item
// may still sit in the output register while the next item is taken. Reset
// clears the sequencer and the output valid; no result is pending after reset.
module integer_to_text_formatter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] magnitude,
	input  wire logic        negative,
	input  wire logic        unsigned_type,
	input  wire logic        plus_flag,
	input  wire logic        space_flag,
	input  wire logic        alternate_flag,
	input  wire logic        upper_case,
	input  wire logic signed [6:0] precision,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       character,
	output logic             last,
	output logic             empty_res
);
	import itf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [VAL_W-1:0]  val_q;
	logic [1:0]        act_q;
	logic              upper_q;
	logic              alt_q;
	logic              sgn_q;
	logic [7:0]        sgn_ch_q;
	logic [PREC_W-1:0] prec_q;
	logic              empty_q;
	logic              pre_q;
	logic [7:0]        pre_ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W:0]    ndig_q;
	logic [PREC_W-1:0] pos_q;

	logic              ovalid_q;
	logic [7:0]        ochar_q;
	logic              olast_q;
	logic              oempty_q;

	logic              accept;
	logic              slot_free;
	logic [PREC_W-1:0] prec_in;
	logic              is_dec_in;
	logic              empty_in;
	logic              bcd_start;
	logic              bcd_done;
	logic [BCD_W-1:0]  bcd;
	logic [3:0]        scan_dig;
	logic [3:0]        emit_dig;
	logic [IDX_W:0]    ndig_scan;
	logic [PREC_W-1:0] total;

	// precision: negative means none; saturate the rest
	always_comb begin
		if (precision[6])
			prec_in = '0;
		else if (precision[5:0] > MAX_PRECISION)
			prec_in = MAX_PRECISION;
		else
			prec_in = precision[5:0];
	end

	assign is_dec_in = (action == ACT_DEC);
	assign empty_in  = !precision[6] && (prec_in == '0) && (magnitude == '0) &&
	                   (is_dec_in || (action == ACT_OCT && !alternate_flag));

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign slot_free  = !ovalid_q || res_ready;
	assign bcd_start  = accept && is_dec_in && !empty_in;

	itf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (magnitude),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// digit at a given index in the current radix
	function automatic logic [3:0] digit_at(input logic [IDX_W-1:0] idx,
	                                        input logic [1:0] act,
	                                        input logic [VAL_W-1:0] v,
	                                        input logic [BCD_W-1:0] b);
		logic [VAL_W+1:0] vo;
		vo = {2'b00, v};
		case (act)
			ACT_DEC: digit_at = b[{idx, 2'b00} +: 4];
			ACT_OCT: digit_at = {1'b0, vo[7'(idx) * 7'd3 +: 3]};
			default: digit_at = v[{idx[3:0], 2'b00} +: 4];
		endcase
	endfunction

	assign scan_dig  = digit_at(idx_q, act_q, val_q, bcd);
	assign emit_dig  = digit_at(pos_q[IDX_W-1:0], act_q, val_q, bcd);
	assign ndig_scan = {1'b0, idx_q} + 1'b1;
	assign total     = (PREC_W'(ndig_scan) > prec_q) ? PREC_W'(ndig_scan) : prec_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			pre_q    <= 1'b0;
		end else begin
			// load a new beat into the output register, or drop the one taken
			if (state_q == ST_EMIT && slot_free)
				ovalid_q <= 1'b1;
			else if (res_ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (empty_in)
							state_q <= ST_EMIT;
						else if (is_dec_in)
							state_q <= ST_CONV;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_CONV: begin
					if (bcd_done)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_dig == 4'd0 && idx_q != '0) begin
						// hold: keep stepping down past leading zeros
					end else begin
						state_q <= ST_EMIT;
						if (act_q == ACT_DEC)
							pre_q <= sgn_q;
						else if (act_q == ACT_OCT)
							pre_q <= alt_q && (val_q != '0) &&
							         (prec_q <= PREC_W'(ndig_scan));
						else
							pre_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (empty_q) begin
							state_q <= ST_IDLE;
						end else if (pre_q) begin
							pre_q <= 1'b0;
						end else if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields and counters
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q    <= magnitude;
			act_q    <= action;
			upper_q  <= upper_case;
			alt_q    <= alternate_flag;
			prec_q   <= prec_in;
			empty_q  <= empty_in;
			sgn_q    <= !unsigned_type && (negative || plus_flag || space_flag);
			sgn_ch_q <= negative ? CH_MINUS : (plus_flag ? CH_PLUS : CH_SPACE);
			case (action)
				ACT_DEC: idx_q <= TOP_DEC;
				ACT_OCT: idx_q <= TOP_OCT;
				default: idx_q <= TOP_HEX;
			endcase
		end
		if (state_q == ST_SCAN) begin
			if (scan_dig == 4'd0 && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end else begin
				ndig_q   <= ndig_scan;
				pos_q    <= total - 1'b1;
				pre_ch_q <= (act_q == ACT_DEC) ? sgn_ch_q : CH_ZERO;
			end
		end
		if (state_q == ST_EMIT && slot_free) begin
			if (empty_q) begin
				ochar_q  <= CH_NUL;
				olast_q  <= 1'b1;
				oempty_q <= 1'b1;
			end else if (pre_q) begin
				ochar_q  <= pre_ch_q;
				olast_q  <= 1'b0;
				oempty_q <= 1'b0;
			end else begin
				// pad with zeros above the leading digit
				if (PREC_W'(ndig_q) > pos_q)
					ochar_q <= digit_char(emit_dig, upper_q);
				else
					ochar_q <= CH_ZERO;
				olast_q  <= (pos_q == '0);
				oempty_q <= 1'b0;
				if (pos_q != '0)
					pos_q <= pos_q - 1'b1;
			end
		end
	end

	assign res_valid = ovalid_q;
	assign character = ochar_q;
	assign last      = olast_q;
	assign empty_res = oempty_q;

endmodule
`default_nettype wire
